// ===== design/assert_macros.svh =====
// assertion helpers included by the top design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_PROP(name, ck, rn, prop) \
	name: assert property (@(posedge ck) disable iff (!rn) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(name, ck, rn, cond) \
	`ASSERT_PROP(name, ck, rn, !(cond))
`else
`define ASSERT_PROP(name, ck, rn, prop)
`define ASSERT_NEVER(name, ck, rn, cond)
`endif

`endif

// ===== design/rgbycc_pkg.sv =====
package rgbycc_pkg;

	typedef enum logic [1:0] {
		MODE_YUV    = 2'd0,
		MODE_STUDIO = 2'd1,
		MODE_INV    = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	localparam logic CFG_IDX_MODE  = 1'b0;
	localparam logic CFG_IDX_ORDER = 1'b1;

	// integer bits left after dropping the fraction of a matrix row sum
	localparam int TruncW = 14;
	// width used for the final clamp
	localparam int SatW = 20;
	// register stages from input to output
	localparam int PipeDepth = 7;

	typedef struct packed {
		mode_t mode;
		logic  bgr;
	} cfg_t;

	typedef struct packed {
		mode_t                    mode;
		logic [7:0]               r;
		logic [7:0]               b;
		logic [2:0][TruncW-1:0]   t;
	} mtx_out_t;

	function automatic logic [7:0] sat8(input logic signed [SatW-1:0] v);
		logic [7:0] res;
		if (v < 0) begin
			res = 8'd0;
		end else if (v > 20'sd255) begin
			res = 8'd255;
		end else begin
			res = v[7:0];
		end
		return res;
	endfunction

endpackage

// ===== design/rgbycc_cfg_regs.sv =====
module rgbycc_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [1:0]          cfg_data,
	output rgbycc_pkg::cfg_t    cfg
);

	rgbycc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode <= rgbycc_pkg::MODE_YUV;
			cfg_q.bgr  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rgbycc_pkg::CFG_IDX_MODE:  cfg_q.mode <= rgbycc_pkg::mode_t'(cfg_data);
				rgbycc_pkg::CFG_IDX_ORDER: cfg_q.bgr  <= cfg_data[0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/rgbycc_matrix.sv =====
module rgbycc_matrix #(
	parameter int COEF_FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rgbycc_pkg::cfg_t       cfg,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             comp_first,
	input  logic [7:0]             comp_second,
	input  logic [7:0]             comp_third,
	output logic                   out_valid,
	input  logic                   out_ready,
	output rgbycc_pkg::mtx_out_t   out_data
);

	localparam int CW = COEF_FRAC_BITS + 3;
	localparam int PW = CW + 9;
	localparam int SW = COEF_FRAC_BITS + rgbycc_pkg::TruncW;

	// forward yuv luma weights
	localparam logic signed [CW-1:0] K_YR =
		CW'(((64'd299 << COEF_FRAC_BITS) + 64'd500) / 64'd1000);
	localparam logic signed [CW-1:0] K_YG =
		CW'(((64'd587 << COEF_FRAC_BITS) + 64'd500) / 64'd1000);
	localparam logic signed [CW-1:0] K_YB =
		CW'(((64'd114 << COEF_FRAC_BITS) + 64'd500) / 64'd1000);

	// studio range matrix
	localparam logic signed [CW-1:0] K_SYR =
		CW'(((64'd25678906250 << COEF_FRAC_BITS) + 64'd50000000000) / 64'd100000000000);
	localparam logic signed [CW-1:0] K_SYG =
		CW'(((64'd49631640625 << COEF_FRAC_BITS) + 64'd50000000000) / 64'd100000000000);
	localparam logic signed [CW-1:0] K_SYB =
		CW'(((64'd9790625000 << COEF_FRAC_BITS) + 64'd50000000000) / 64'd100000000000);
	localparam logic signed [CW-1:0] K_SBR =
		CW'(((64'd14822265625 << COEF_FRAC_BITS) + 64'd50000000000) / 64'd100000000000);
	localparam logic signed [CW-1:0] K_SBG =
		CW'(((64'd29099218750 << COEF_FRAC_BITS) + 64'd50000000000) / 64'd100000000000);
	localparam logic signed [CW-1:0] K_SBB =
		CW'(((64'd43921484375 << COEF_FRAC_BITS) + 64'd50000000000) / 64'd100000000000);
	localparam logic signed [CW-1:0] K_SRG =
		CW'(((64'd36778906250 << COEF_FRAC_BITS) + 64'd50000000000) / 64'd100000000000);
	localparam logic signed [CW-1:0] K_SRB =
		CW'(((64'd7142578125 << COEF_FRAC_BITS) + 64'd50000000000) / 64'd100000000000);

	// inverse matrix
	localparam logic signed [CW-1:0] K_ONE = CW'(64'd1 << COEF_FRAC_BITS);
	localparam logic signed [CW-1:0] K_RV =
		CW'(((64'd1402 << COEF_FRAC_BITS) + 64'd500) / 64'd1000);
	localparam logic signed [CW-1:0] K_GU =
		CW'(((64'd34414 << COEF_FRAC_BITS) + 64'd50000) / 64'd100000);
	localparam logic signed [CW-1:0] K_GV =
		CW'(((64'd71414 << COEF_FRAC_BITS) + 64'd50000) / 64'd100000);
	localparam logic signed [CW-1:0] K_BU =
		CW'(((64'd1772 << COEF_FRAC_BITS) + 64'd500) / 64'd1000);

	localparam logic signed [SW-1:0] OFF_16  = SW'(64'd16 << COEF_FRAC_BITS);
	localparam logic signed [SW-1:0] OFF_128 = SW'(64'd128 << COEF_FRAC_BITS);

	// stage 1: input capture
	logic                    v_s1;
	logic [7:0]              a_s1, g_s1, c_s1;
	rgbycc_pkg::mode_t       mode_s1;
	logic                    bgr_s1;

	// stage 2: products
	logic                    v_s2;
	logic signed [PW-1:0]    prod_s2 [3][3];
	rgbycc_pkg::mode_t       mode_s2;
	logic [7:0]              r_s2, b_s2;

	// stage 3: row sums
	logic                    v_s3;
	logic signed [SW-1:0]    sum_s3 [3];
	rgbycc_pkg::mode_t       mode_s3;
	logic [7:0]              r_s3, b_s3;

	// stage 4: integer rows
	logic                    v_s4;
	rgbycc_pkg::mtx_out_t    data_s4;

	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	assign rdy_s4   = !v_s4 || out_ready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// coefficient and operand selection
	logic [7:0]              r_sel, b_sel;
	logic signed [8:0]       x [3];
	logic signed [CW-1:0]    k [3][3];
	logic signed [PW-1:0]    prod_c [3][3];

	always_comb begin
		r_sel = bgr_s1 ? c_s1 : a_s1;
		b_sel = bgr_s1 ? a_s1 : c_s1;
		for (int i = 0; i < 3; i++) begin
			x[i] = '0;
			for (int j = 0; j < 3; j++) begin
				k[i][j] = '0;
			end
		end
		case (mode_s1)
			rgbycc_pkg::MODE_YUV: begin
				x[0] = $signed({1'b0, r_sel});
				x[1] = $signed({1'b0, g_s1});
				x[2] = $signed({1'b0, b_sel});
				k[0][0] = K_YR;
				k[0][1] = K_YG;
				k[0][2] = K_YB;
			end
			rgbycc_pkg::MODE_STUDIO: begin
				x[0] = $signed({1'b0, r_sel});
				x[1] = $signed({1'b0, g_s1});
				x[2] = $signed({1'b0, b_sel});
				k[0][0] = K_SYR;
				k[0][1] = K_SYG;
				k[0][2] = K_SYB;
				k[1][0] = -K_SBR;
				k[1][1] = -K_SBG;
				k[1][2] = K_SBB;
				k[2][0] = K_SBB;
				k[2][1] = -K_SRG;
				k[2][2] = -K_SRB;
			end
			rgbycc_pkg::MODE_INV: begin
				x[0] = $signed({1'b0, a_s1});
				x[1] = $signed({1'b0, g_s1}) - 9'sd128;
				x[2] = $signed({1'b0, c_s1}) - 9'sd128;
				k[1][0] = K_ONE;
				k[1][1] = -K_GU;
				k[1][2] = -K_GV;
				if (bgr_s1) begin
					k[0][0] = K_ONE;
					k[0][1] = K_BU;
					k[2][0] = K_ONE;
					k[2][2] = K_RV;
				end else begin
					k[0][0] = K_ONE;
					k[0][2] = K_RV;
					k[2][0] = K_ONE;
					k[2][1] = K_BU;
				end
			end
			default: begin
			end
		endcase
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				prod_c[i][j] = k[i][j] * x[j];
			end
		end
	end

	// offsets and row sums
	logic signed [SW-1:0] off [3];
	logic signed [SW-1:0] sum_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			off[i] = '0;
		end
		if (mode_s2 == rgbycc_pkg::MODE_STUDIO) begin
			off[0] = OFF_16;
			off[1] = OFF_128;
			off[2] = OFF_128;
		end
		for (int i = 0; i < 3; i++) begin
			sum_c[i] = SW'(prod_s2[i][0]) + SW'(prod_s2[i][1]) + SW'(prod_s2[i][2])
				+ off[i];
		end
	end

	// drop the fraction, rounding toward zero
	logic signed [SW-1:0]                     q [3];
	logic [2:0][rgbycc_pkg::TruncW-1:0]       t_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			q[i] = sum_s3[i] >>> COEF_FRAC_BITS;
			if (sum_s3[i][SW-1] && (sum_s3[i][COEF_FRAC_BITS-1:0] != '0)) begin
				q[i] = q[i] + SW'(1);
			end
			t_c[i] = q[i][rgbycc_pkg::TruncW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			a_s1    <= comp_first;
			g_s1    <= comp_second;
			c_s1    <= comp_third;
			mode_s1 <= cfg.mode;
			bgr_s1  <= cfg.bgr;
		end
		if (rdy_s2 && v_s1) begin
			prod_s2 <= prod_c;
			mode_s2 <= mode_s1;
			r_s2    <= r_sel;
			b_s2    <= b_sel;
		end
		if (rdy_s3 && v_s2) begin
			sum_s3  <= sum_c;
			mode_s3 <= mode_s2;
			r_s3    <= r_s2;
			b_s3    <= b_s2;
		end
		if (rdy_s4 && v_s3) begin
			data_s4.mode <= mode_s3;
			data_s4.r    <= r_s3;
			data_s4.b    <= b_s3;
			data_s4.t    <= t_c;
		end
	end

	assign out_valid = v_s4;
	assign out_data  = data_s4;

endmodule

// ===== design/rgbycc_chroma.sv =====
module rgbycc_chroma #(
	parameter int COEF_FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  rgbycc_pkg::mtx_out_t   in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [7:0]             res_first,
	output logic [7:0]             res_second,
	output logic [7:0]             res_third
);

	localparam int CW  = COEF_FRAC_BITS + 3;
	localparam int DW  = 15;
	localparam int PW2 = CW + DW;
	localparam int TW2 = PW2 - COEF_FRAC_BITS;
	localparam int SatW = rgbycc_pkg::SatW;

	localparam logic signed [CW-1:0] K_U =
		CW'(((64'd492 << COEF_FRAC_BITS) + 64'd500) / 64'd1000);
	localparam logic signed [CW-1:0] K_V =
		CW'(((64'd877 << COEF_FRAC_BITS) + 64'd500) / 64'd1000);

	// stage 5: chroma differences and clamped rows
	logic                    v_s5;
	rgbycc_pkg::mode_t       mode_s5;
	logic signed [DW-1:0]    db_s5, dr_s5;
	logic [2:0][7:0]         sat_s5;

	// stage 6: chroma products
	logic                    v_s6;
	rgbycc_pkg::mode_t       mode_s6;
	logic signed [PW2-1:0]   pu_s6, pv_s6;
	logic [2:0][7:0]         sat_s6;

	// stage 7: output register
	logic                    v_s7;
	logic [7:0]              res0_s7, res1_s7, res2_s7;

	logic rdy_s5, rdy_s6, rdy_s7;

	assign rdy_s7   = !v_s7 || out_ready;
	assign rdy_s6   = !v_s6 || rdy_s7;
	assign rdy_s5   = !v_s5 || rdy_s6;
	assign in_ready = rdy_s5;

	logic signed [DW-1:0]  y_ext;
	logic signed [DW-1:0]  db_c, dr_c;
	logic [2:0][7:0]       sat_c;

	always_comb begin
		y_ext = DW'($signed(in_data.t[0]));
		db_c  = $signed({{(DW-8){1'b0}}, in_data.b}) - y_ext;
		dr_c  = $signed({{(DW-8){1'b0}}, in_data.r}) - y_ext;
		for (int i = 0; i < 3; i++) begin
			sat_c[i] = rgbycc_pkg::sat8(SatW'($signed(in_data.t[i])));
		end
	end

	logic signed [PW2-1:0] pu_c, pv_c;

	assign pu_c = K_U * db_s5;
	assign pv_c = K_V * dr_s5;

	// round toward zero, add the chroma offset and clamp
	logic signed [PW2-1:0]  qu, qv;
	logic signed [TW2-1:0]  tu, tv;
	logic signed [SatW-1:0] cu, cv;
	logic [7:0]             r0_c, r1_c, r2_c;

	always_comb begin
		qu = pu_s6 >>> COEF_FRAC_BITS;
		if (pu_s6[PW2-1] && (pu_s6[COEF_FRAC_BITS-1:0] != '0)) begin
			qu = qu + PW2'(1);
		end
		qv = pv_s6 >>> COEF_FRAC_BITS;
		if (pv_s6[PW2-1] && (pv_s6[COEF_FRAC_BITS-1:0] != '0)) begin
			qv = qv + PW2'(1);
		end
		tu = qu[TW2-1:0];
		tv = qv[TW2-1:0];
		cu = SatW'(tu) + SatW'(128);
		cv = SatW'(tv) + SatW'(128);
		case (mode_s6) inside
			rgbycc_pkg::MODE_YUV: begin
				r0_c = sat_s6[0];
				r1_c = rgbycc_pkg::sat8(cu);
				r2_c = rgbycc_pkg::sat8(cv);
			end
			rgbycc_pkg::MODE_STUDIO, rgbycc_pkg::MODE_INV: begin
				r0_c = sat_s6[0];
				r1_c = sat_s6[1];
				r2_c = sat_s6[2];
			end
			default: begin
				r0_c = '0;
				r1_c = '0;
				r2_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (rdy_s5) v_s5 <= in_valid;
			if (rdy_s6) v_s6 <= v_s5;
			if (rdy_s7) v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && in_valid) begin
			mode_s5 <= in_data.mode;
			db_s5   <= db_c;
			dr_s5   <= dr_c;
			sat_s5  <= sat_c;
		end
		if (rdy_s6 && v_s5) begin
			mode_s6 <= mode_s5;
			pu_s6   <= pu_c;
			pv_s6   <= pv_c;
			sat_s6  <= sat_s5;
		end
		if (rdy_s7 && v_s6) begin
			res0_s7 <= r0_c;
			res1_s7 <= r1_c;
			res2_s7 <= r2_c;
		end
	end

	assign out_valid  = v_s7;
	assign res_first  = res0_s7;
	assign res_second = res1_s7;
	assign res_third  = res2_s7;

endmodule

// ===== design/rgb_ycbcr_pixel_converter_top.sv =====
// each accepted transaction is registered in stages s1 through s7; s7 holds its result on the outputs
// throughput: one pixel per cycle while out_stall is low; seven register stages, bubbles collapse under stall
// the limit per stage is one multiply of at most 19x15 bits or one row add of three products and an offset
// reset: pipeline valid bits clear, mode returns to forward yuv weights, rgb order
// no memories, so no clearing pass after reset
`include "assert_macros.svh"

module rgb_ycbcr_pixel_converter_top #(
	parameter int COEF_FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [1:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  comp_first,
	input  logic [7:0]  comp_second,
	input  logic [7:0]  comp_third,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  res_first,
	output logic [7:0]  res_second,
	output logic [7:0]  res_third
);

	localparam int OccW = $clog2(rgbycc_pkg::PipeDepth + 2);

	rgbycc_pkg::cfg_t      cfg;
	rgbycc_pkg::mtx_out_t  mtx_data;
	logic                  mtx_valid;
	logic                  chr_ready;
	logic                  in_ready;

	rgbycc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rgbycc_matrix #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_matrix (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.comp_first  (comp_first),
		.comp_second (comp_second),
		.comp_third  (comp_third),
		.out_valid   (mtx_valid),
		.out_ready   (chr_ready),
		.out_data    (mtx_data)
	);

	rgbycc_chroma #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_chroma (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (mtx_valid),
		.in_ready   (chr_ready),
		.in_data    (mtx_data),
		.out_valid  (out_valid),
		.out_ready  (!out_stall),
		.res_first  (res_first),
		.res_second (res_second),
		.res_third  (res_third)
	);

	assign in_stall = !in_ready;

	// transactions in flight
	logic [OccW-1:0] occ_q;
	logic            acc_in, acc_out;

	assign acc_in  = in_valid && !in_stall;
	assign acc_out = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + OccW'(acc_in) - OccW'(acc_out);
		end
	end

	`ASSERT_PROP(a_stall_only_full, clk, arst_n, in_stall |-> (out_valid && out_stall))
	`ASSERT_NEVER(a_occ_bound, clk, arst_n, occ_q > OccW'(rgbycc_pkg::PipeDepth))
	`ASSERT_NEVER(a_no_phantom, clk, arst_n, out_valid && (occ_q == '0))

endmodule

// ===== test/rgb_ycbcr_pixel_converter_top_tb.sv =====
`timescale 1ns / 100ps

module rgb_ycbcr_pixel_converter_top_tb;

	localparam int FRAC = 16;
	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASES = 9;
	localparam int RANDOM_PER_PHASE = 80;

	// index 0 is the first component
	typedef logic [2:0][7:0] pix_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [1:0] cfg_data = 2'b00;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] comp_first = 8'd0;
	logic [7:0] comp_second = 8'd0;
	logic [7:0] comp_third = 8'd0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] res_first;
	logic [7:0] res_second;
	logic [7:0] res_third;

	rgbycc_pkg::mode_t cur_mode = rgbycc_pkg::MODE_YUV;
	logic cur_bgr = 1'b0;

	pix_t pixel_q[$];
	pix_t converted_q[$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int gap_left = 0;
	int stall_left = 0;
	int errors = 0;
	int cycles = 0;

	rgb_ycbcr_pixel_converter_top #(
		.COEF_FRAC_BITS(FRAC)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.comp_first(comp_first),
		.comp_second(comp_second),
		.comp_third(comp_third),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.res_first(res_first),
		.res_second(res_second),
		.res_third(res_third)
	);

	always #5 clk = ~clk;

	function automatic longint coef(input longint unsigned n, input longint unsigned d);
		return longint'(((n << FRAC) + d / 2) / d);
	endfunction

	function automatic longint drop_frac(input longint v);
		if (v < 0) begin
			return -((-v) >> FRAC);
		end
		return v >> FRAC;
	endfunction

	function automatic logic [7:0] clamp8(input longint v);
		if (v < 0) begin
			return 8'd0;
		end
		if (v > 255) begin
			return 8'd255;
		end
		return v[7:0];
	endfunction

	function automatic pix_t convert_pixel(input pix_t px);
		longint a, g, c, r, b, y, cb, cr;
		pix_t res;
		a = px[0];
		g = px[1];
		c = px[2];
		r = cur_bgr ? c : a;
		b = cur_bgr ? a : c;
		res = '0;
		case (cur_mode)
		rgbycc_pkg::MODE_YUV: begin
			y = drop_frac(coef(299, 1000) * r + coef(587, 1000) * g + coef(114, 1000) * b);
			cb = 128 + drop_frac(coef(492, 1000) * (b - y));
			cr = 128 + drop_frac(coef(877, 1000) * (r - y));
			res[0] = clamp8(y);
			res[1] = clamp8(cb);
			res[2] = clamp8(cr);
		end
		rgbycc_pkg::MODE_STUDIO: begin
			y = (longint'(16) << FRAC) + coef(64'd25678906250, 64'd100000000000) * r
				+ coef(64'd49631640625, 64'd100000000000) * g
				+ coef(64'd9790625000, 64'd100000000000) * b;
			cb = (longint'(128) << FRAC) - coef(64'd14822265625, 64'd100000000000) * r
				- coef(64'd29099218750, 64'd100000000000) * g
				+ coef(64'd43921484375, 64'd100000000000) * b;
			cr = (longint'(128) << FRAC) + coef(64'd43921484375, 64'd100000000000) * r
				- coef(64'd36778906250, 64'd100000000000) * g
				- coef(64'd7142578125, 64'd100000000000) * b;
			res[0] = clamp8(drop_frac(y));
			res[1] = clamp8(drop_frac(cb));
			res[2] = clamp8(drop_frac(cr));
		end
		rgbycc_pkg::MODE_INV: begin
			y = a << FRAC;
			cb = g - 128;
			cr = c - 128;
			r = clamp8(drop_frac(y + coef(1402, 1000) * cr));
			g = clamp8(drop_frac(y - coef(34414, 100000) * cb - coef(71414, 100000) * cr));
			b = clamp8(drop_frac(y + coef(1772, 1000) * cb));
			res[0] = cur_bgr ? b[7:0] : r[7:0];
			res[1] = g[7:0];
			res[2] = cur_bgr ? r[7:0] : b[7:0];
		end
		default: begin
			res = '0;
		end
		endcase
		return res;
	endfunction

	function automatic logic [7:0] pick_comp();
		case ($urandom_range(0, 7))
		0: return 8'd0;
		1: return 8'd255;
		2: return 8'd128;
		default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic write_reg(input logic idx, input logic [1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == rgbycc_pkg::CFG_IDX_MODE) begin
			cur_mode = rgbycc_pkg::mode_t'(val);
		end else begin
			cur_bgr = val[0];
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (pixel_q.size() != 0 || in_valid || converted_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (rgbycc_pkg::PipeDepth + 3) @(negedge clk);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		pix_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			comp_first <= 8'd0;
			comp_second <= 8'd0;
			comp_third <= 8'd0;
		end else begin
			if (in_valid && !in_stall) begin
				converted_q.push_back(convert_pixel({comp_third, comp_second, comp_first}));
			end
			if (!in_valid || !in_stall) begin
				if (gap_left == 0 && pixel_q.size() != 0
					&& $urandom_range(0, 99) < send_idle_pct) begin
					gap_left = $urandom_range(1, 8);
				end
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pixel_q.size() != 0) begin
					nxt = pixel_q.pop_front();
					comp_first <= nxt[0];
					comp_second <= nxt[1];
					comp_third <= nxt[2];
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		pix_t got, want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				got = {res_third, res_second, res_first};
				if (converted_q.size() == 0) begin
					$display("%0t: unexpected transaction %0d/%0d/%0d", $time,
						got[0], got[1], got[2]);
					errors++;
				end else begin
					want = converted_q.pop_front();
					for (int i = 0; i < 3; i++) begin
						if (got[i] !== want[i]) begin
							$display("%0t: component %0d expected %0d got %0d", $time, i,
								want[i], got[i]);
							errors++;
						end
					end
				end
			end
			if (stall_left == 0 && $urandom_range(0, 99) < recv_idle_pct) begin
				stall_left = $urandom_range(1, 8);
			end
			if (stall_left != 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("rgb_ycbcr_pixel_converter_top_tb: FAIL");
			$finish;
		end
	end

	initial begin
		int mode_val;
		logic order_bit;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			mode_val = (p < 4) ? p : ((p < 8) ? p - 4 : $urandom_range(0, 3));
			order_bit = (p < 4) ? 1'b0 : ((p < 8) ? 1'b1 : 1'($urandom_range(0, 1)));
			write_reg(rgbycc_pkg::CFG_IDX_MODE, 2'(mode_val));
			// upper data bit is don't-care for the order register
			write_reg(rgbycc_pkg::CFG_IDX_ORDER, {1'($urandom_range(0, 1)), order_bit});
			if (p == PHASES - 1) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else begin
				send_idle_pct = (p % 3 == 0) ? 0 : 10 * $urandom_range(1, 5);
				recv_idle_pct = (p % 3 == 1) ? 0 : 10 * $urandom_range(1, 5);
			end
			@(negedge clk);
			if (p < 3) begin
				for (int i = 0; i < 8; i++) begin
					pixel_q.push_back({{8{i[2]}}, {8{i[1]}}, {8{i[0]}}});
				end
				pixel_q.push_back({8'd128, 8'd128, 8'd128});
			end
			for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
				pixel_q.push_back({pick_comp(), pick_comp(), pick_comp()});
			end
		end
		wait_drained();
		if (errors == 0) begin
			$display("rgb_ycbcr_pixel_converter_top_tb: PASS");
		end else begin
			$display("rgb_ycbcr_pixel_converter_top_tb: FAIL");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/rgbycc_pkg.sv
design/rgbycc_cfg_regs.sv
design/rgbycc_matrix.sv
design/rgbycc_chroma.sv
design/rgb_ycbcr_pixel_converter_top.sv
test/rgb_ycbcr_pixel_converter_top_tb.sv
